// File: hw/rtl/script_token_scanner_core_defines.svh
// Assertion macros used by the scanner back end (sts_back).
// No dependencies.
`ifndef SCRIPT_TOKEN_SCANNER_CORE_DEFINES_SVH
`define SCRIPT_TOKEN_SCANNER_CORE_DEFINES_SVH
// Property that holds when not in reset.
`define STS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Property that holds also during reset.
`define STS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);
`endif

// File: hw/rtl/sts_pkg.sv
// Types, constants and helper functions of the script token scanner.
// No dependencies.
`default_nettype none
package sts_pkg;
   localparam int OffsetBits = 32;
   localparam int LengthBits = 16;
   localparam int LineBits   = 24;
   localparam int QueueDepth = 4;
   localparam int QueueIdxBits = 2;

   localparam logic [LengthBits-1:0] LenMax = {LengthBits{1'b1}};
   localparam logic [LineBits-1:0]   LineMax = {LineBits{1'b1}};

   localparam logic [5:0] T_END = 6'd0;
   localparam logic [5:0] T_IDENT = 6'd1;
   localparam logic [5:0] T_STRING = 6'd2;
   localparam logic [5:0] T_INT = 6'd3;
   localparam logic [5:0] T_FLOAT = 6'd4;
   localparam logic [5:0] T_KW0 = 6'd5;
   localparam logic [5:0] T_LPAREN = 6'd18;
   localparam logic [5:0] T_RPAREN = 6'd19;
   localparam logic [5:0] T_LBRACE = 6'd20;
   localparam logic [5:0] T_RBRACE = 6'd21;
   localparam logic [5:0] T_SEMI = 6'd22;
   localparam logic [5:0] T_COMMA = 6'd23;
   localparam logic [5:0] T_DOT = 6'd24;
   localparam logic [5:0] T_MINUS = 6'd25;
   localparam logic [5:0] T_MINUSEQ = 6'd26;
   localparam logic [5:0] T_ARROW = 6'd27;
   localparam logic [5:0] T_PERCENT = 6'd28;
   localparam logic [5:0] T_PLUS = 6'd30;
   localparam logic [5:0] T_SLASH = 6'd32;
   localparam logic [5:0] T_STAR = 6'd34;
   localparam logic [5:0] T_BSLASH = 6'd36;
   localparam logic [5:0] T_BANG = 6'd37;
   localparam logic [5:0] T_EQEQ = 6'd39;
   localparam logic [5:0] T_LESS = 6'd40;
   localparam logic [5:0] T_GREATER = 6'd43;
   localparam logic [5:0] T_LBRK2 = 6'd46;
   localparam logic [5:0] T_RBRK2 = 6'd47;
   localparam logic [5:0] T_AND = 6'd48;
   localparam logic [5:0] T_OR = 6'd49;
   localparam logic [5:0] T_ASSIGN = 6'd50;
   localparam logic [5:0] T_ERROR = 6'd51;

   localparam logic [1:0] E_NONE = 2'd0;
   localparam logic [1:0] E_BADCHAR = 2'd1;
   localparam logic [1:0] E_UNTERM = 2'd2;

   typedef enum logic [22:0] {
      M_IDLE     = 23'h000001,
      M_IDENT    = 23'h000002,
      M_INT      = 23'h000004,
      M_INTDOT   = 23'h000008,
      M_FLOAT    = 23'h000010,
      M_STRING   = 23'h000020,
      M_LINECMT  = 23'h000040,
      M_BLOCKCMT = 23'h000080,
      M_MINUS    = 23'h000100,
      M_MINUSEQ  = 23'h000200,
      M_LESS     = 23'h000400,
      M_GREATER  = 23'h000800,
      M_PERCENT  = 23'h001000,
      M_PLUS     = 23'h002000,
      M_SLASH    = 23'h004000,
      M_STAR     = 23'h008000,
      M_BANG     = 23'h010000,
      M_EQ       = 23'h020000,
      M_LBRACK   = 23'h040000,
      M_RBRACK   = 23'h080000,
      M_AMP      = 23'h100000,
      M_BAR      = 23'h200000,
      M_COLON    = 23'h400000
   } mode_type;

   typedef struct packed {
      logic [5:0]            token_type;
      logic [1:0]            error_kind;
      logic [OffsetBits-1:0] start_offset;
      logic [LengthBits-1:0] token_length;
      logic [LineBits-1:0]   line;
      logic                  last_of_run;
   } token_type_s_type;

   // Up to three tokens produced by one byte, packed in slots 0..count-1.
   typedef struct packed {
      logic [1:0]          count;
      token_type_s_type [2:0] tok;
   } burst_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
      logic [63:0] s;
      case (k)
         4'd0: s = "else    ";
         4'd1: s = "false   ";
         4'd2: s = "for     ";
         4'd3: s = "if      ";
         4'd4: s = "include ";
         4'd5: s = "let     ";
         4'd6: s = "print   ";
         4'd7: s = "return  ";
         4'd8: s = "true    ";
         4'd9: s = "var     ";
         4'd10: s = "wait    ";
         4'd11: s = "while   ";
         4'd12: s = "yield   ";
         default: s = 64'd0;
      endcase
      return s[63 - 8*p -: 8];
   endfunction

   function automatic logic [3:0] kw_len(input logic [3:0] k);
      case (k)
         4'd0: return 4'd4;
         4'd1: return 4'd5;
         4'd2: return 4'd3;
         4'd3: return 4'd2;
         4'd4: return 4'd7;
         4'd5: return 4'd3;
         4'd6: return 4'd5;
         4'd7: return 4'd6;
         4'd8: return 4'd4;
         4'd9: return 4'd3;
         4'd10: return 4'd4;
         4'd11: return 4'd5;
         4'd12: return 4'd5;
         default: return 4'd0;
      endcase
   endfunction

   // Next keyword candidate after byte c at position pos; 0 means none.
   // Candidates sharing a prefix are grouped, so the first match in the list
   // with the same prefix is found by comparing with the current candidate.
   function automatic logic [5:0] kw_next(input logic [5:0] cur, input logic [3:0] pos,
                                          input logic [7:0] c);
      logic [5:0] r;
      logic       same;
      logic [3:0] k;
      r = 6'd0;
      k = cur[3:0] - 4'd1;
      for (int j = 12; j >= 0; j--) begin
         if (pos == 4'd0) begin
            if (kw_char(4'(j), 3'd0) == c) r = 6'(j + 1);
         end else if (pos < 4'd8 && cur >= 6'd1 && cur <= 6'd13 && pos <= kw_len(k)
                      && kw_len(4'(j)) > pos) begin
            same = 1'b1;
            for (int p = 0; p < 7; p++)
               if (4'(p) < pos && kw_char(4'(j), 3'(p)) != kw_char(k, 3'(p))) same = 1'b0;
            if (same && kw_char(4'(j), pos[2:0]) == c) r = 6'(j + 1);
         end
      end
      return r;
   endfunction
endpackage
`default_nettype wire

// File: hw/rtl/sts_front.sv
// Front end of the scanner: accepts bytes, keeps the scan state and forms
// the burst of tokens each byte causes. Depends on sts_pkg.
`default_nettype none
module sts_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_ch,
   input  wire logic             queue_full,
   output logic                  burst_valid,
   output sts_pkg::burst_type    burst
);
   sts_pkg::mode_type mode_ff, mode_in;
   logic [5:0] kw_ff, kw_in;
   logic [sts_pkg::OffsetBits-1:0] start_ff, start_in, off_ff, off_in;
   logic [sts_pkg::LengthBits-1:0] run_ff, run_in;
   logic [sts_pkg::LineBits-1:0]   line_ff, line_in;
   logic accept;

   assign req_stall = queue_full;
   assign accept = req_valid && !queue_full;
   assign burst_valid = accept;

   always_comb begin
      logic [7:0] c;
      logic used, end_seen;
      logic [1:0] n;
      logic [3:0] kpos;
      sts_pkg::token_type_s_type t;
      c = req_ch;
      mode_in = mode_ff; kw_in = kw_ff; start_in = start_ff;
      run_in = run_ff; line_in = line_ff;
      used = 1'b0; end_seen = 1'b0; n = 2'd0;
      burst = '0;
      t = '0;
      kpos = (run_ff > sts_pkg::LengthBits'(8)) ? 4'd8 : run_ff[3:0];
      // Pending token first.
      if (mode_ff != sts_pkg::M_IDLE) begin
         mode_in = sts_pkg::M_IDLE;
         case (mode_ff)
            sts_pkg::M_IDENT: begin
               if (sts_pkg::is_alpha(c) || sts_pkg::is_digit(c)) begin
                  kw_in = sts_pkg::kw_next(kw_ff, kpos, c);
                  if (run_ff != sts_pkg::LenMax) run_in = run_ff + 1'b1;
                  mode_in = sts_pkg::M_IDENT; used = 1'b1;
               end else begin
                  t.token_type = sts_pkg::T_IDENT;
                  if (kw_ff >= 6'd1 && kw_ff <= 6'd13 &&
                      run_ff == sts_pkg::LengthBits'(sts_pkg::kw_len(kw_ff[3:0] - 4'd1)))
                     t.token_type = sts_pkg::T_KW0 + kw_ff - 6'd1;
                  t.start_offset = start_ff; t.token_length = run_ff;
                  burst.tok[n] = t; n = n + 2'd1;
               end
            end
            sts_pkg::M_INT, sts_pkg::M_FLOAT: begin
               if (sts_pkg::is_digit(c)) begin
                  if (run_ff != sts_pkg::LenMax) run_in = run_ff + 1'b1;
                  mode_in = mode_ff; used = 1'b1;
               end else if (mode_ff == sts_pkg::M_INT && c == 8'h2e) begin
                  mode_in = sts_pkg::M_INTDOT; used = 1'b1;
               end else begin
                  t.token_type = (mode_ff == sts_pkg::M_INT) ? sts_pkg::T_INT
                                                             : sts_pkg::T_FLOAT;
                  t.start_offset = start_ff; t.token_length = run_ff;
                  burst.tok[n] = t; n = n + 2'd1;
               end
            end
            sts_pkg::M_INTDOT: begin
               if (sts_pkg::is_digit(c)) begin
                  run_in = (run_ff >= sts_pkg::LenMax - 1'b1) ? sts_pkg::LenMax
                                                              : run_ff + 2'd2;
                  mode_in = sts_pkg::M_FLOAT; used = 1'b1;
               end else begin
                  t.token_type = sts_pkg::T_INT;
                  t.start_offset = start_ff; t.token_length = run_ff;
                  burst.tok[n] = t; n = n + 2'd1;
                  t = '0;
                  t.token_type = sts_pkg::T_DOT; t.start_offset = off_ff - 1'b1;
                  t.token_length = sts_pkg::LengthBits'(1);
                  burst.tok[n] = t; n = n + 2'd1;
               end
            end
            sts_pkg::M_STRING: begin
               if (c == 8'h00) begin
                  t.token_type = sts_pkg::T_ERROR; t.error_kind = sts_pkg::E_UNTERM;
                  t.start_offset = start_ff;
                  burst.tok[n] = t; n = n + 2'd1;
               end else begin
                  used = 1'b1; mode_in = sts_pkg::M_STRING;
                  if (run_ff != sts_pkg::LenMax) run_in = run_ff + 1'b1;
                  if (c == 8'h22) begin
                     t.token_type = sts_pkg::T_STRING; t.start_offset = start_ff;
                     t.token_length = run_in;
                     burst.tok[n] = t; n = n + 2'd1;
                     mode_in = sts_pkg::M_IDLE;
                  end else if (c == 8'h0a && line_ff != sts_pkg::LineMax)
                     line_in = line_ff + 1'b1;
               end
            end
            sts_pkg::M_LINECMT: begin
               if (c != 8'h0a && c != 8'h00) begin
                  used = 1'b1; mode_in = sts_pkg::M_LINECMT;
               end
            end
            sts_pkg::M_BLOCKCMT: begin
               if (c != 8'h00) begin
                  used = 1'b1; mode_in = sts_pkg::M_BLOCKCMT;
                  if (c == 8'h0a) begin
                     if (line_ff != sts_pkg::LineMax) line_in = line_ff + 1'b1;
                  end else if (c == 8'h7e) mode_in = sts_pkg::M_IDLE;
               end
            end
            sts_pkg::M_MINUS: begin
               t.start_offset = start_ff;
               if (c == 8'h3d) begin
                  mode_in = sts_pkg::M_MINUSEQ; used = 1'b1;
               end else begin
                  used = (c == 8'h3e);
                  t.token_type = used ? sts_pkg::T_ARROW : sts_pkg::T_MINUS;
                  t.token_length = used ? sts_pkg::LengthBits'(2) : sts_pkg::LengthBits'(1);
                  burst.tok[n] = t; n = n + 2'd1;
               end
            end
            sts_pkg::M_MINUSEQ: begin
               used = (c == 8'h3e);
               t.start_offset = start_ff;
               t.token_type = used ? sts_pkg::T_ARROW : sts_pkg::T_MINUSEQ;
               t.token_length = used ? sts_pkg::LengthBits'(3) : sts_pkg::LengthBits'(2);
               burst.tok[n] = t; n = n + 2'd1;
            end
            sts_pkg::M_LESS, sts_pkg::M_GREATER: begin
               logic [5:0] base;
               logic [7:0] self;
               base = (mode_ff == sts_pkg::M_LESS) ? sts_pkg::T_LESS : sts_pkg::T_GREATER;
               self = (mode_ff == sts_pkg::M_LESS) ? 8'h3c : 8'h3e;
               t.start_offset = start_ff; t.token_length = sts_pkg::LengthBits'(2);
               used = 1'b1;
               if (c == 8'h3d) t.token_type = base + 6'd1;
               else if (c == self) t.token_type = base + 6'd2;
               else begin
                  t.token_type = base; t.token_length = sts_pkg::LengthBits'(1);
                  used = 1'b0;
               end
               burst.tok[n] = t; n = n + 2'd1;
            end
            sts_pkg::M_PERCENT, sts_pkg::M_PLUS, sts_pkg::M_SLASH, sts_pkg::M_STAR,
            sts_pkg::M_BANG: begin
               logic [5:0] base;
               case (mode_ff)
                  sts_pkg::M_PERCENT: base = sts_pkg::T_PERCENT;
                  sts_pkg::M_PLUS:    base = sts_pkg::T_PLUS;
                  sts_pkg::M_SLASH:   base = sts_pkg::T_SLASH;
                  sts_pkg::M_STAR:    base = sts_pkg::T_STAR;
                  default:            base = sts_pkg::T_BANG;
               endcase
               used = (c == 8'h3d);
               t.start_offset = start_ff;
               t.token_type = used ? base + 6'd1 : base;
               t.token_length = used ? sts_pkg::LengthBits'(2) : sts_pkg::LengthBits'(1);
               burst.tok[n] = t; n = n + 2'd1;
            end
            default: begin
               logic [7:0] pc;
               logic [5:0] pt;
               case (mode_ff)
                  sts_pkg::M_EQ:     begin pc = 8'h3d; pt = sts_pkg::T_EQEQ; end
                  sts_pkg::M_LBRACK: begin pc = 8'h5b; pt = sts_pkg::T_LBRK2; end
                  sts_pkg::M_RBRACK: begin pc = 8'h5d; pt = sts_pkg::T_RBRK2; end
                  sts_pkg::M_AMP:    begin pc = 8'h26; pt = sts_pkg::T_AND; end
                  sts_pkg::M_BAR:    begin pc = 8'h7c; pt = sts_pkg::T_OR; end
                  default:           begin pc = 8'h3d; pt = sts_pkg::T_ASSIGN; end
               endcase
               used = (c == pc);
               t.start_offset = start_ff;
               if (used) begin
                  t.token_type = pt; t.token_length = sts_pkg::LengthBits'(2);
               end else begin
                  t.token_type = sts_pkg::T_ERROR; t.error_kind = sts_pkg::E_BADCHAR;
               end
               burst.tok[n] = t; n = n + 2'd1;
            end
         endcase
      end
      // Byte scanned afresh with nothing pending.
      if (!used) begin
         t = '0;
         t.start_offset = off_ff;
         t.token_length = sts_pkg::LengthBits'(1);
         mode_in = sts_pkg::M_IDLE;
         if (c == 8'h00) begin
            t.token_type = sts_pkg::T_END; t.token_length = '0;
            burst.tok[n] = t; n = n + 2'd1; end_seen = 1'b1;
         end else if (sts_pkg::is_alpha(c)) begin
            mode_in = sts_pkg::M_IDENT; kw_in = sts_pkg::kw_next(6'd0, 4'd0, c);
         end else if (sts_pkg::is_digit(c)) mode_in = sts_pkg::M_INT;
         else begin
            case (c)
               8'h20, 8'h0d, 8'h09: ;
               8'h0a: if (line_in != sts_pkg::LineMax) line_in = line_in + 1'b1;
               8'h23: mode_in = sts_pkg::M_LINECMT;
               8'h7e: mode_in = sts_pkg::M_BLOCKCMT;
               8'h22: mode_in = sts_pkg::M_STRING;
               8'h2d: mode_in = sts_pkg::M_MINUS;
               8'h3c: mode_in = sts_pkg::M_LESS;
               8'h3e: mode_in = sts_pkg::M_GREATER;
               8'h25: mode_in = sts_pkg::M_PERCENT;
               8'h2b: mode_in = sts_pkg::M_PLUS;
               8'h2f: mode_in = sts_pkg::M_SLASH;
               8'h2a: mode_in = sts_pkg::M_STAR;
               8'h21: mode_in = sts_pkg::M_BANG;
               8'h3d: mode_in = sts_pkg::M_EQ;
               8'h5b: mode_in = sts_pkg::M_LBRACK;
               8'h5d: mode_in = sts_pkg::M_RBRACK;
               8'h26: mode_in = sts_pkg::M_AMP;
               8'h7c: mode_in = sts_pkg::M_BAR;
               8'h3a: mode_in = sts_pkg::M_COLON;
               8'h28, 8'h29, 8'h7b, 8'h7d, 8'h3b, 8'h2c, 8'h2e, 8'h5c: begin
                  case (c)
                     8'h28: t.token_type = sts_pkg::T_LPAREN;
                     8'h29: t.token_type = sts_pkg::T_RPAREN;
                     8'h7b: t.token_type = sts_pkg::T_LBRACE;
                     8'h7d: t.token_type = sts_pkg::T_RBRACE;
                     8'h3b: t.token_type = sts_pkg::T_SEMI;
                     8'h2c: t.token_type = sts_pkg::T_COMMA;
                     8'h2e: t.token_type = sts_pkg::T_DOT;
                     default: t.token_type = sts_pkg::T_BSLASH;
                  endcase
                  burst.tok[n] = t; n = n + 2'd1;
               end
               default: begin
                  t.token_type = sts_pkg::T_ERROR; t.error_kind = sts_pkg::E_BADCHAR;
                  t.token_length = '0;
                  burst.tok[n] = t; n = n + 2'd1;
               end
            endcase
         end
         if (mode_in != sts_pkg::M_IDLE && mode_in != sts_pkg::M_LINECMT &&
             mode_in != sts_pkg::M_BLOCKCMT) begin
            start_in = off_ff; run_in = sts_pkg::LengthBits'(1);
         end
      end
      // Tokens carry the line count from before this byte, since a newline
      // never comes ahead of a token emitted by the same byte.
      for (int i = 0; i < 3; i++) burst.tok[i].line = line_ff;
      if (n != 2'd0) burst.tok[n - 2'd1].last_of_run = 1'b1;
      burst.count = n;
      off_in = off_ff + 1'b1;
      if (end_seen) begin
         mode_in = sts_pkg::M_IDLE; kw_in = '0; start_in = '0; off_in = '0;
         run_in = '0; line_in = sts_pkg::LineBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sts_pkg::M_IDLE; kw_ff <= '0; start_ff <= '0; off_ff <= '0;
         run_ff <= '0; line_ff <= sts_pkg::LineBits'(1);
      end else if (accept) begin
         mode_ff <= mode_in; kw_ff <= kw_in; start_ff <= start_in; off_ff <= off_in;
         run_ff <= run_in; line_ff <= line_in;
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/sts_back.sv
// Back end of the scanner: a short queue of token bursts that hands the
// tokens out one at a time. Depends on sts_pkg and script_token_scanner_core_defines.svh.
`default_nettype none
`include "script_token_scanner_core_defines.svh"
module sts_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             burst_valid,
   input  wire sts_pkg::burst_type burst,
   output logic                  queue_full,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sts_pkg::token_type_s_type rsp_tok
);
   sts_pkg::burst_type q_ff [sts_pkg::QueueDepth];
   logic [sts_pkg::QueueIdxBits-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [sts_pkg::QueueIdxBits:0]   cnt_ff, cnt_in;
   logic [1:0] sub_ff, sub_in;
   logic push, pop_tok, pop_burst, head_empty;

   assign queue_full = (cnt_ff == 3'(sts_pkg::QueueDepth));
   assign push = burst_valid && burst.count != 2'd0;
   assign head_empty = (cnt_ff == '0);
   assign rsp_valid = !head_empty;
   assign rsp_tok = q_ff[rd_ff].tok[sub_ff];
   assign pop_tok = rsp_valid && !rsp_stall;
   assign pop_burst = pop_tok && (sub_ff + 2'd1 == q_ff[rd_ff].count);

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop_burst ? rd_ff + 1'b1 : rd_ff;
      sub_in = pop_burst ? 2'd0 : (pop_tok ? sub_ff + 2'd1 : sub_ff);
      cnt_in = cnt_ff + 3'(push) - 3'(pop_burst);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0; sub_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in; sub_ff <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= burst;
   end

   `STS_ASSERT(a_no_overflow, push |-> !queue_full, "burst pushed into a full queue")
   `STS_ASSERT(a_count_range, cnt_ff <= 3'(sts_pkg::QueueDepth), "queue count out of range")
   `STS_ASSERT(a_last_on_pop, pop_burst |-> rsp_tok.last_of_run, "burst ends without last flag")
   `STS_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "queue not empty after reset")
endmodule
`default_nettype wire

// File: hw/rtl/script_token_scanner_core.sv
// Script token scanner: streaming lexer top level.
// Byte input on the req_ channel, one token per transfer on the rsp_ channel.
// Each accepted request byte yields zero to three tokens, in source order;
// last_of_run marks the final token caused by a byte.
// A byte is accepted in any cycle where req_valid is high and req_stall low,
// so the block sustains one byte per clock. The front end classifies the byte
// and updates the scan state in that cycle; its tokens are registered into a
// four-burst queue and reach the rsp_ port from the queue head.
// Bytes giving three tokens occupy the output for three transfers, so the output
// side sets the rate when many tokens are produced per byte.
// A zero byte emits the end token and returns all scan state to its reset
// value: line 1, offset 0.
// Synchronous active-high reset empties the queue and resets the scan state.
// When the receiver stalls, the head token holds; req_stall rises once the
// queue holds four bursts.
`default_nettype none
module script_token_scanner_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_ch,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [5:0]       rsp_token_type,
   output logic [1:0]       rsp_error_kind,
   output logic [sts_pkg::OffsetBits-1:0] rsp_start_offset,
   output logic [sts_pkg::LengthBits-1:0] rsp_token_length,
   output logic [sts_pkg::LineBits-1:0]   rsp_line,
   output logic             rsp_last_of_run
);
   logic queue_full, burst_valid;
   sts_pkg::burst_type burst;
   sts_pkg::token_type_s_type tok;

   sts_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_ch(req_ch), .queue_full(queue_full), .burst_valid(burst_valid), .burst(burst)
   );

   sts_back u_back (
      .clock(clock), .reset(reset), .burst_valid(burst_valid), .burst(burst),
      .queue_full(queue_full), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_tok(tok)
   );

   assign rsp_token_type = tok.token_type;
   assign rsp_error_kind = tok.error_kind;
   assign rsp_start_offset = tok.start_offset;
   assign rsp_token_length = tok.token_length;
   assign rsp_line = tok.line;
   assign rsp_last_of_run = tok.last_of_run;
endmodule
`default_nettype wire
